// ----- design/assert_macros.svh -----
// Shared assertion shorthands for the watchdog quorum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that cond never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- design/wdq_pkg.sv -----
package wdq_pkg;

    localparam int SLOTS     = 8;
    localparam int ID_WIDTH  = 32;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 4;

    typedef enum logic [1:0] {
        MODE_REGISTER   = 2'd0,
        MODE_UNREGISTER = 2'd1,
        MODE_FEED       = 2'd2,
        MODE_QUERY      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_INV_STATE = 3'd1,
        STAT_INV_ARG   = 3'd2,
        STAT_NO_SLOT   = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIALIZED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = CFG_IDX_W'(3);

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef logic [SLOTS-1:0] slot_mask_t;

    // Isolate the lowest set bit.
    function automatic slot_mask_t lowest_one(input slot_mask_t m);
        return m & (~m + slot_mask_t'(1));
    endfunction

    function automatic logic [CNT_W-1:0] popcount(input slot_mask_t m);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < SLOTS; i++) begin
            c = c + CNT_W'(m[i]);
        end
        return c;
    endfunction

endpackage

// ----- design/multi_task_watchdog_quorum.sv -----
// Multi-task watchdog quorum supervisor.
//
// Input channel (s_valid/s_ready): one request per handshake, carrying a
// mode (register, unregister, feed, status query) and a task identifier.
// Result channel (m_valid/m_ready): one result per request with a status
// code, the fallback feed and task kick pulses, and the registered, fed
// and required counts after the request.
// Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high;
// cfg_index selects initialized, enabled, fallback_enabled or the vote
// policy and bit cfg_data is written. Indexes beyond three are
// dropped. Write only while no request is in flight.
// Timing: a request is captured at acceptance, executed against the slot
// table in the EXEC state (all slot compares run in parallel) and its
// result registered as it executes. The next request is taken while a
// result still waits; if the receiver stalls, execution holds until the
// result register drains, and s_ready stays low from the capture until
// that request has executed.
// Reset: all slots free, fed mask clear, not initialized, supervision
// and fallback enabled, policy all; no result pending.
module multi_task_watchdog_quorum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [wdq_pkg::ID_WIDTH-1:0]  s_task_id,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status_code,
    output logic                          m_fallback_feed,
    output logic                          m_task_kick,
    output logic [wdq_pkg::CNT_W-1:0]     m_registered_count,
    output logic [wdq_pkg::CNT_W-1:0]     m_fed_count,
    output logic [wdq_pkg::CNT_W-1:0]     m_required_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wdq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_data
);

    wdq_pkg::ctrl_cmd_t cmd;

    // Take configuration writes at any time.
    assign cfg_ready = 1'b1;

    // Sequence each request: capture, execute, present.
    wdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Slot table, fed mask, configuration and result registers.
    wdq_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .s_mode             (s_mode),
        .s_task_id          (s_task_id),
        .cfg_we             (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .m_status_code      (m_status_code),
        .m_fallback_feed    (m_fallback_feed),
        .m_task_kick        (m_task_kick),
        .m_registered_count (m_registered_count),
        .m_fed_count        (m_fed_count),
        .m_required_count   (m_required_count)
    );

endmodule

// ----- design/wdq_ctrl.sv -----
`include "assert_macros.svh"

module wdq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output wdq_pkg::ctrl_cmd_t cmd
);

    wdq_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wdq_pkg::ST_IDLE: begin
                if (s_valid) state_next = wdq_pkg::ST_EXEC;
            end
            wdq_pkg::ST_EXEC: begin
                if (!m_valid_reg || m_ready) state_next = wdq_pkg::ST_IDLE;
            end
            default: state_next = wdq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            wdq_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            wdq_pkg::ST_EXEC: begin
                cmd.commit = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit)   m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wdq_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `ASSERT_NEVER(a_commit_over_full, aclk, aresetn, cmd.commit && m_valid_reg && !m_ready, "commit would overwrite an untaken result")
    `ASSERT_HOLDS(a_commit_shows, aclk, aresetn, cmd.commit |=> m_valid_reg, "committed result not presented")
    `ASSERT_HOLDS(a_capture_exec, aclk, aresetn, cmd.capture |=> (state_reg == wdq_pkg::ST_EXEC && !s_ready), "captured request not executed")

endmodule

// ----- design/wdq_datapath.sv -----
`include "assert_macros.svh"

module wdq_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wdq_pkg::ctrl_cmd_t            cmd,
    input  logic [1:0]                    s_mode,
    input  logic [wdq_pkg::ID_WIDTH-1:0]  s_task_id,
    input  logic                          cfg_we,
    input  logic [wdq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_data,
    output logic [2:0]                    m_status_code,
    output logic                          m_fallback_feed,
    output logic                          m_task_kick,
    output logic [wdq_pkg::CNT_W-1:0]     m_registered_count,
    output logic [wdq_pkg::CNT_W-1:0]     m_fed_count,
    output logic [wdq_pkg::CNT_W-1:0]     m_required_count
);

    wdq_pkg::mode_t               mode_reg;
    logic [wdq_pkg::ID_WIDTH-1:0] id_reg;
    logic [wdq_pkg::ID_WIDTH-1:0] ids_reg [wdq_pkg::SLOTS];
    wdq_pkg::slot_mask_t          active_reg, active_next;
    wdq_pkg::slot_mask_t          fed_reg, fed_next;
    logic init_reg, en_reg, fb_reg, pol_reg;

    wdq_pkg::status_t         status_reg, status_next;
    logic                     ffeed_reg, ffeed_next;
    logic                     kick_reg, kick_next;
    logic [wdq_pkg::CNT_W-1:0] regc_reg, regc_next;
    logic [wdq_pkg::CNT_W-1:0] fedc_reg, fedc_next;
    logic [wdq_pkg::CNT_W-1:0] reqc_reg, reqc_next;

    wdq_pkg::slot_mask_t match, hit_oh, free_oh, wr_oh, fed_mark;
    logic                id_zero, hit, met;

    // Compare lanes, one per slot.
    always_comb begin
        for (int i = 0; i < wdq_pkg::SLOTS; i++) begin
            match[i] = active_reg[i] && (ids_reg[i] == id_reg);
        end
    end

    assign id_zero  = (id_reg == '0);
    assign hit_oh   = id_zero ? '0 : wdq_pkg::lowest_one(match);
    assign hit      = |hit_oh;
    assign free_oh  = wdq_pkg::lowest_one(~active_reg);
    assign fed_mark = fed_reg | hit_oh;
    assign met      = pol_reg ? |(fed_mark & active_reg)
                              : ((fed_mark & active_reg) == active_reg);

    always_comb begin
        active_next = active_reg;
        fed_next    = fed_reg;
        wr_oh       = '0;
        status_next = wdq_pkg::STAT_OK;
        ffeed_next  = 1'b0;
        kick_next   = 1'b0;
        if (mode_reg != wdq_pkg::MODE_QUERY && !init_reg) begin
            status_next = wdq_pkg::STAT_INV_STATE;
        end else begin
            case (mode_reg)
                wdq_pkg::MODE_REGISTER: begin
                    if (id_zero) begin
                        status_next = wdq_pkg::STAT_INV_ARG;
                    end else if (!hit) begin
                        if (free_oh == '0) begin
                            status_next = wdq_pkg::STAT_NO_SLOT;
                        end else begin
                            wr_oh       = free_oh;
                            active_next = active_reg | free_oh;
                        end
                    end
                    fed_next = fed_reg & active_next;
                end
                wdq_pkg::MODE_UNREGISTER: begin
                    if (!hit) begin
                        status_next = wdq_pkg::STAT_NOT_FOUND;
                    end else begin
                        active_next = active_reg & ~hit_oh;
                        fed_next    = fed_reg & active_next;
                    end
                end
                wdq_pkg::MODE_FEED: begin
                    if (!en_reg) begin
                        status_next = wdq_pkg::STAT_OK;
                    end else if (id_zero) begin
                        status_next = wdq_pkg::STAT_INV_ARG;
                    end else begin
                        kick_next = 1'b1;
                        if (!hit) begin
                            status_next = wdq_pkg::STAT_NOT_FOUND;
                        end else if (fb_reg && active_reg != '0 && met) begin
                            ffeed_next = 1'b1;
                            fed_next   = '0;
                        end else begin
                            fed_next = fed_mark;
                        end
                    end
                end
                default: begin
                    status_next = wdq_pkg::STAT_OK;
                end
            endcase
        end
    end

    assign regc_next = wdq_pkg::popcount(active_next);
    assign fedc_next = wdq_pkg::popcount(active_next & fed_next);
    assign reqc_next = pol_reg ? wdq_pkg::CNT_W'(regc_next != '0) : regc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            fed_reg    <= '0;
            init_reg   <= 1'b0;
            en_reg     <= 1'b1;
            fb_reg     <= 1'b1;
            pol_reg    <= 1'b0;
        end else begin
            if (cmd.commit) begin
                active_reg <= active_next;
                fed_reg    <= fed_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    wdq_pkg::CFG_INITIALIZED: init_reg <= cfg_data;
                    wdq_pkg::CFG_ENABLED:     en_reg   <= cfg_data;
                    wdq_pkg::CFG_FALLBACK:    fb_reg   <= cfg_data;
                    wdq_pkg::CFG_POLICY:      pol_reg  <= cfg_data;
                    default:                  init_reg <= init_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= wdq_pkg::mode_t'(s_mode);
            id_reg   <= s_task_id;
        end
        if (cmd.commit) begin
            status_reg <= status_next;
            ffeed_reg  <= ffeed_next;
            kick_reg   <= kick_next;
            regc_reg   <= regc_next;
            fedc_reg   <= fedc_next;
            reqc_reg   <= reqc_next;
        end
        for (int i = 0; i < wdq_pkg::SLOTS; i++) begin
            if (cmd.commit && wr_oh[i]) ids_reg[i] <= id_reg;
        end
    end

    assign m_status_code      = status_reg;
    assign m_fallback_feed    = ffeed_reg;
    assign m_task_kick        = kick_reg;
    assign m_registered_count = regc_reg;
    assign m_fed_count        = fedc_reg;
    assign m_required_count   = reqc_reg;

    `ASSERT_NEVER(a_fed_inactive, aclk, aresetn, (fed_reg & ~active_reg) != '0, "fed bit set on an inactive slot")
    `ASSERT_HOLDS(a_ffeed_clears, aclk, aresetn, (cmd.commit && ffeed_next) |=> (fed_reg == '0 && kick_reg), "fallback feed without kick or clear")

endmodule
